// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing when SYNTH is
// defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scroll axis lock detector: assertion failed");
// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== sv/slad_pkg.sv =====
// ----------------------------------------------------------------------------
// Scroll axis lock detector package
// Types, register codes, reset values and arithmetic helpers.
// ----------------------------------------------------------------------------
package slad_pkg;

    localparam int MOTION_W = 24;
    localparam int TIME_W   = 16;
    localparam int SUM_W    = 32;
    localparam int THR_W    = 24;
    localparam int WEIGHT_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        MODE_FREE   = 2'd0,
        MODE_LOCK_V = 2'd1,
        MODE_LOCK_H = 2'd2
    } lock_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENGAGE    = 3'd0,
        CFG_BREAKAWAY = 3'd1,
        CFG_TIMEOUT   = 3'd2,
        CFG_DOM_W     = 3'd3,
        CFG_OTHER_W   = 3'd4
    } cfg_index_t;

    localparam logic [THR_W-1:0]    ENGAGE_RESET    = 24'd6250;
    localparam logic [THR_W-1:0]    BREAKAWAY_RESET = 24'd18750;
    localparam logic [TIME_W-1:0]   TIMEOUT_RESET   = 16'd500;
    localparam logic [WEIGHT_W-1:0] DOM_W_RESET     = 4'd3;
    localparam logic [WEIGHT_W-1:0] OTHER_W_RESET   = 4'd2;

    typedef struct packed {
        logic [THR_W-1:0]    engage_threshold;
        logic [THR_W-1:0]    breakaway_threshold;
        logic [TIME_W-1:0]   idle_timeout_ms;
        logic [WEIGHT_W-1:0] dominance_weight;
        logic [WEIGHT_W-1:0] other_weight;
    } slad_cfg_t;

    typedef struct packed {
        lock_mode_t               mode;
        logic signed [SUM_W-1:0]  sum_h;
        logic signed [SUM_W-1:0]  sum_v;
        logic [TIME_W-1:0]        last_ms;
    } slad_state_t;

    // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
    function automatic logic [SUM_W-1:0] mag32(input logic signed [SUM_W-1:0] x);
        logic [SUM_W-1:0] r;
        r = x[SUM_W-1] ? (~x + 32'd1) : x;
        return r;
    endfunction

    // Signed add of a motion value to a sum, clamped at the 32-bit limits.
    function automatic logic signed [SUM_W-1:0] sat_add32(
        input logic signed [SUM_W-1:0]    a,
        input logic signed [MOTION_W-1:0] b
    );
        logic [SUM_W:0] s;
        logic signed [SUM_W-1:0] r;
        s = {a[SUM_W-1], a} + {{(SUM_W-MOTION_W+1){b[MOTION_W-1]}}, b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = s[SUM_W-1:0];
        end
        return r;
    endfunction

    // Weighted magnitude of a is at least the weighted magnitude of b.
    function automatic logic dominates(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b,
        input logic [WEIGHT_W-1:0]     wa,
        input logic [WEIGHT_W-1:0]     wb
    );
        logic [SUM_W+WEIGHT_W-1:0] pa;
        logic [SUM_W+WEIGHT_W-1:0] pb;
        pa = {{WEIGHT_W{1'b0}}, mag32(a)} * {{SUM_W{1'b0}}, wa};
        pb = {{WEIGHT_W{1'b0}}, mag32(b)} * {{SUM_W{1'b0}}, wb};
        return pa >= pb;
    endfunction

endpackage

// ===== sv/slad_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the thresholds, timeout and weights written over the config channel.
// ----------------------------------------------------------------------------
module slad_cfg_regs
    import slad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output slad_cfg_t             cfg
);

    slad_cfg_t cfg_reg;
    slad_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_ENGAGE:    cfg_next.engage_threshold    = cfg_data[THR_W-1:0];
                CFG_BREAKAWAY: cfg_next.breakaway_threshold = cfg_data[THR_W-1:0];
                CFG_TIMEOUT:   cfg_next.idle_timeout_ms     = cfg_data[TIME_W-1:0];
                CFG_DOM_W:     cfg_next.dominance_weight    = cfg_data[WEIGHT_W-1:0];
                CFG_OTHER_W:   cfg_next.other_weight        = cfg_data[WEIGHT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.engage_threshold    <= ENGAGE_RESET;
            cfg_reg.breakaway_threshold <= BREAKAWAY_RESET;
            cfg_reg.idle_timeout_ms     <= TIMEOUT_RESET;
            cfg_reg.dominance_weight    <= DOM_W_RESET;
            cfg_reg.other_weight        <= OTHER_W_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/slad_step.sv =====
// ----------------------------------------------------------------------------
// Lock decision step
// Combinational next-state and result logic for one motion item.
// ----------------------------------------------------------------------------
module slad_step
    import slad_pkg::*;
(
    input  logic signed [MOTION_W-1:0] h_motion,
    input  logic signed [MOTION_W-1:0] v_motion,
    input  logic [TIME_W-1:0]          now_ms,
    input  slad_state_t                state,
    input  slad_cfg_t                  cfg,
    output slad_state_t                state_next,
    output logic                       clear_scroll
);

    logic signed [SUM_W-1:0] h_ext;
    logic signed [SUM_W-1:0] v_ext;
    logic [TIME_W-1:0]       elapsed;
    logic                    is_idle;
    logic                    release_lock;
    logic                    item_dom_v;
    logic                    item_dom_h;
    logic signed [SUM_W-1:0] lv_sum_h;
    logic signed [SUM_W-1:0] lh_sum_v;
    logic signed [SUM_W-1:0] fr_sum_h;
    logic signed [SUM_W-1:0] fr_sum_v;
    logic                    lv_break;
    logic                    lh_break;
    logic                    fr_lock_v;
    logic                    fr_lock_h;
    lock_mode_t              mode_next;
    logic signed [SUM_W-1:0] sum_h_next;
    logic signed [SUM_W-1:0] sum_v_next;
    logic [TIME_W-1:0]       last_ms_next;

    assign h_ext   = {{(SUM_W-MOTION_W){h_motion[MOTION_W-1]}}, h_motion};
    assign v_ext   = {{(SUM_W-MOTION_W){v_motion[MOTION_W-1]}}, v_motion};
    assign elapsed = now_ms - state.last_ms;
    assign is_idle = (h_motion == '0) && (v_motion == '0);
    assign release_lock = (elapsed > cfg.idle_timeout_ms) && (state.mode != MODE_FREE);

    // Locked modes: cross-axis sum restarts when the locked axis wins this item.
    assign item_dom_v = dominates(v_ext, h_ext, cfg.dominance_weight, cfg.other_weight);
    assign item_dom_h = dominates(h_ext, v_ext, cfg.dominance_weight, cfg.other_weight);
    assign lv_sum_h   = sat_add32(item_dom_v ? '0 : state.sum_h, h_motion);
    assign lh_sum_v   = sat_add32(item_dom_h ? '0 : state.sum_v, v_motion);
    assign lv_break   = mag32(lv_sum_h) >= {{(SUM_W-THR_W){1'b0}}, cfg.breakaway_threshold};
    assign lh_break   = mag32(lh_sum_v) >= {{(SUM_W-THR_W){1'b0}}, cfg.breakaway_threshold};

    // Free mode: both sums grow, then vertical dominance or horizontal engage.
    assign fr_sum_h  = sat_add32(state.sum_h, h_motion);
    assign fr_sum_v  = sat_add32(state.sum_v, v_motion);
    assign fr_lock_v = dominates(fr_sum_v, fr_sum_h, cfg.dominance_weight, cfg.other_weight);
    assign fr_lock_h = mag32(fr_sum_h) >= {{(SUM_W-THR_W){1'b0}}, cfg.engage_threshold};

    always_comb begin
        mode_next = state.mode;
        if (is_idle) begin
            if (release_lock) begin
                mode_next = MODE_FREE;
            end
        end else begin
            case (state.mode)
                MODE_LOCK_V: begin
                    if (lv_break) mode_next = MODE_LOCK_H;
                end
                MODE_LOCK_H: begin
                    if (lh_break) mode_next = MODE_LOCK_V;
                end
                default: begin
                    if (fr_lock_v) begin
                        mode_next = MODE_LOCK_V;
                    end else if (fr_lock_h) begin
                        mode_next = MODE_LOCK_H;
                    end else begin
                        mode_next = MODE_FREE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        sum_h_next   = state.sum_h;
        sum_v_next   = state.sum_v;
        last_ms_next = state.last_ms;
        clear_scroll = 1'b0;
        if (is_idle) begin
            if (release_lock) begin
                sum_h_next   = '0;
                sum_v_next   = '0;
                clear_scroll = 1'b1;
            end
        end else begin
            last_ms_next = now_ms;
            case (state.mode)
                MODE_LOCK_V: begin
                    sum_h_next = lv_sum_h;
                    if (lv_break) begin
                        sum_v_next   = '0;
                        clear_scroll = 1'b1;
                    end
                end
                MODE_LOCK_H: begin
                    sum_v_next = lh_sum_v;
                    if (lh_break) begin
                        sum_h_next   = '0;
                        clear_scroll = 1'b1;
                    end
                end
                default: begin
                    sum_h_next = fr_sum_h;
                    sum_v_next = fr_sum_v;
                    if (fr_lock_v) begin
                        sum_h_next = '0;
                    end else if (fr_lock_h) begin
                        sum_v_next = '0;
                    end
                end
            endcase
        end
    end

    assign state_next.mode    = mode_next;
    assign state_next.sum_h   = sum_h_next;
    assign state_next.sum_v   = sum_v_next;
    assign state_next.last_ms = last_ms_next;

endmodule

// ===== sv/scroll_axis_lock_detector.sv =====
// ----------------------------------------------------------------------------
// Scroll axis lock detector
// Tracks free, locked-vertical and locked-horizontal scroll modes from a
// stream of motion reports and flags when downstream scroll totals must clear.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bit first)
//  -------   ---------  ------------------------------------------------------
//  s_        in         tdata[63:0]: h_motion[23:0], v_motion[23:0], now_ms[15:0]
//  m_        out        tdata[7:0]:  mode[1:0], clear_scroll, zero padding
//  cfg_      in         cfg_index[2:0], cfg_data[23:0] (register write)
//
// One transfer is accepted per cycle while the result side keeps up. A report waits
// in the input register, where a single decision pass updates the mode and sums that
// feed the next report, and then sits in the result register. A stalled result side
// fills both registers before s_tready drops. Reset is synchronous and active low; it
// frees the lock, clears the sums and time stamp, and loads the default thresholds,
// timeout and weights.
//
`include "assert_macros.svh"

module scroll_axis_lock_detector
    import slad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Motion reports
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // h_motion[23:0], v_motion[47:24], now_ms[63:48]
    // Mode results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // mode[1:0], clear_scroll[2], zero[7:3]
    // Register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    slad_cfg_t cfg;

    // Input register
    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic signed [MOTION_W-1:0] in_h_reg;
    logic signed [MOTION_W-1:0] in_v_reg;
    logic [TIME_W-1:0]          in_now_reg;

    // Tracking state
    slad_state_t state_reg;
    slad_state_t state_next;
    logic        step_clear;

    // Result register
    logic        out_valid_reg;
    logic        out_valid_next;
    lock_mode_t  out_mode_reg;
    logic        out_clear_reg;

    logic in_load;
    logic advance;

    // Both registers full with the result held back.
    logic stall_hold;
    // The report being consumed frees a lock.
    logic lock_release;
    // Both cross-axis sums are empty.
    logic sums_empty;

    // The held report moves on whenever the result register is free or is
    // being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_load  = s_tvalid && s_tready;

    assign in_valid_next  = in_load ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    slad_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slad_step u_step (
        .h_motion     (in_h_reg),
        .v_motion     (in_v_reg),
        .now_ms       (in_now_reg),
        .state        (state_reg),
        .cfg          (cfg),
        .state_next   (state_next),
        .clear_scroll (step_clear)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: MODE_FREE, sum_h: '0, sum_v: '0, last_ms: '0};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_h_reg   <= s_tdata[23:0];
            in_v_reg   <= s_tdata[47:24];
            in_now_reg <= s_tdata[63:48];
        end
        if (advance) begin
            out_mode_reg  <= state_next.mode;
            out_clear_reg <= step_clear;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_clear_reg, out_mode_reg};

    assign stall_hold   = in_valid_reg && out_valid_reg && !m_tready;
    assign lock_release = advance && step_clear && (state_next.mode == MODE_FREE);
    assign sums_empty   = (state_reg.sum_h == '0) && (state_reg.sum_v == '0);

    // The input side only stalls with both registers full and the result held.
    `ASSERT_NEVER(a_stall_only_when_full, aclk, aresetn, !s_tready && !stall_hold)
    // The reported mode is the mode the tracker has just moved to.
    `ASSERT_CLK(a_result_matches_state, aclk, aresetn, advance |=> out_mode_reg == state_reg.mode)
    // A released lock leaves both cross-axis sums empty.
    `ASSERT_CLK(a_release_clears_sums, aclk, aresetn, lock_release |=> sums_empty)
    // Tracking state only moves when a report is consumed.
    `ASSERT_CLK(a_state_held_when_idle, aclk, aresetn, !advance |=> $stable(state_reg))

endmodule
